### rtl/core/wfps_pkg.sv
// ----------------------------------------------------------------------------
// wfps_pkg: shared types and constants
// Payload structs, state encoding, twiddle table and rounding helper for the
// windowed FFT power spectrum block.
// ----------------------------------------------------------------------------
package wfps_pkg;

	localparam int NFFT_MAX = 64;
	localparam int ADDR_W   = 6;
	localparam int BUF_W    = 48;
	localparam int MAG_W    = 40;
	localparam int ACC_W    = 112;
	localparam int ENERGY_W = 37;
	localparam int DIV_W    = 38;
	localparam int POWER_W  = 48;
	localparam int CFG_W    = 32;

	localparam logic [1:0] REG_STEP_DAYS = 2'd0;
	localparam logic [1:0] REG_FIRST_BIN = 2'd1;
	localparam logic [1:0] REG_LAST_BIN  = 2'd2;

	localparam logic [31:0] STEP_RESET  = 32'd65536;
	localparam logic [5:0]  FIRST_RESET = 6'd0;
	localparam logic [5:0]  LAST_RESET  = 6'd32;

	typedef struct packed {
		logic signed [15:0] sample;
		logic [15:0]        weight;
		logic               last;
	} in_item_t;

	typedef struct packed {
		logic [5:0]  bin_index;
		logic [47:0] power;
		logic        short_segment;
		logic        last_bin_flag;
	} out_item_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_PAD,
		ST_SW_CHK,
		ST_BF_CHK,
		ST_RD_A,
		ST_RD_B,
		ST_CAP,
		ST_MUL0,
		ST_MUL1,
		ST_MUL2,
		ST_MUL3,
		ST_MUL4,
		ST_WR_A,
		ST_WR_B,
		ST_PW_RD,
		ST_PW_CAP,
		ST_SQ_RE,
		ST_SQ_IM,
		ST_SCALE,
		ST_DIV,
		ST_LOAD
	} state_t;

	typedef struct packed {
		logic signed [16:0] c;
		logic signed [16:0] s;
	} twiddle_t;

	// cos(2*pi*m/64) in Q1.15, quarter wave
	localparam logic signed [16:0] COS_TAB [17] = '{
		17'sd32768, 17'sd32610, 17'sd32138, 17'sd31357, 17'sd30274, 17'sd28899,
		17'sd27246, 17'sd25330, 17'sd23170, 17'sd20788, 17'sd18205, 17'sd15447,
		17'sd12540, 17'sd9512,  17'sd6393,  17'sd3212,  17'sd0
	};

	function automatic twiddle_t twiddle(input logic [4:0] m);
		twiddle_t    t;
		logic [5:0]  mm;
		mm = {1'b0, m};
		if (mm <= 6'd16) begin
			t.c = COS_TAB[5'(mm)];
			t.s = COS_TAB[5'(6'd16 - mm)];
		end else begin
			t.c = -COS_TAB[5'(6'd32 - mm)];
			t.s = COS_TAB[5'(mm - 6'd16)];
		end
		return t;
	endfunction

	// shift right by 15, half away from zero
	function automatic logic signed [47:0] round_q15(input logic signed [65:0] x);
		logic [65:0] mag;
		logic [65:0] r;
		logic [47:0] t;
		mag = x[65] ? 66'(-x) : 66'(x);
		r   = (mag + 66'd16384) >> 15;
		t   = r[47:0];
		return x[65] ? signed'(-t) : signed'(t);
	endfunction

endpackage

### rtl/core/wfps_ram.sv
// ----------------------------------------------------------------------------
// wfps_ram: generic single-write, single-read RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module wfps_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### rtl/core/windowed_fft_power_spectrum.sv
// ----------------------------------------------------------------------------
// windowed_fft_power_spectrum: periodogram PSD of one windowed segment
// Weighted samples go to a 64-entry complex buffer; on the closing beat the
// segment is zero-padded, transformed in place and one PSD beat per bin sent.
// ----------------------------------------------------------------------------
// Use:
//  - Input channel (in_valid / in_stall / in_data): one beat per sample with
//    its window weight; the beat with last set closes the segment. Samples
//    beyond 64 are dropped, but their last flag still closes the segment.
//  - Output channel (out_valid / out_stall / out_data): one beat per bin in
//    [first_bin, min(last_bin, nfft/2)] (all bins if that range is empty),
//    last_bin_flag on the final one. A segment of under 4 samples gives one
//    beat with short_segment set.
//  - Sample beats are taken one per cycle while idle. After the closing beat
//    in_stall stays high until the last result has been loaded.
//  - Sequence: zero padding, then bit reversal with a swap per reversed
//    pair, then the butterflies through the single shared multiplier (64
//    points: 192 butterflies). Each bin then takes two shift-add squarings
//    and the step scaling (their length follows the operand bit lengths)
//    and a restoring divide of the 112-bit numerator. A short segment goes
//    straight to loading its beat.
//  - A stalled result holds in the output register while the next bin is
//    computed; the closing result frees the input side at once.
//  - Reset clears control state and loads the register defaults; the buffer
//    needs no clearing since every entry is written before it is read.
// ----------------------------------------------------------------------------
module windowed_fft_power_spectrum (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  wfps_pkg::in_item_t   in_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output wfps_pkg::out_item_t  out_data,
	input  logic                 cfg_we,
	input  logic [1:0]           cfg_addr,
	input  logic [31:0]          cfg_wdata
);

	wfps_pkg::state_t state_q, state_d;

	// configuration
	logic [31:0] step_q;
	logic [5:0]  first_q, last_q;

	// segment capture
	logic [6:0]                       cnt_q;
	logic [wfps_pkg::ENERGY_W-1:0]    energy_q;
	logic [2:0]                       bits_q;
	logic [wfps_pkg::DIV_W-1:0]       wss_q;
	logic                             short_q;

	// FFT sequencer
	logic                             fft_q;
	logic [6:0]                       idx_q;
	logic [2:0]                       st_q;
	logic [wfps_pkg::ADDR_W-1:0]      addr_a_q, addr_b_q;
	logic signed [16:0]               c_q, s_q;
	logic signed [wfps_pkg::BUF_W-1:0] vr_q, vi_q, ur_q, ui_q, tr_q, ti_q;
	logic signed [64:0]               prod_q;
	logic signed [65:0]               acc_q;

	// power stage
	logic [5:0]                       k_q, hi_q, nyq_q;
	logic [wfps_pkg::MAG_W-1:0]       mi_q, m_q;
	logic [wfps_pkg::ACC_W-1:0]       md_q, pacc_q, num_q;
	logic [wfps_pkg::DIV_W-1:0]       rem_q;
	logic [6:0]                       dcnt_q;
	logic [wfps_pkg::POWER_W-1:0]     q_q;
	logic                             over_q;

	wfps_pkg::out_item_t              out_q;
	logic                             out_valid_q;

	// buffer ports
	logic                             ram_we;
	logic [wfps_pkg::ADDR_W-1:0]      ram_waddr, ram_raddr;
	logic [wfps_pkg::BUF_W-1:0]       ram_wre, ram_wim, ram_rre, ram_rim;

	// combinational helpers
	logic                             accept_in, out_free, cnt_room;
	logic [6:0]                       n_now, nfft;
	logic [2:0]                       bits_now;
	logic signed [32:0]               samp_prod;
	logic [31:0]                      w_sq;
	logic [37:0]                      energy_sum;
	logic [6:0]                       half, kk, base, bf_u, bf_v;
	logic [4:0]                       tw_m;
	wfps_pkg::twiddle_t               tw;
	logic [5:0]                       rev6;
	logic [6:0]                       rev;
	logic [5:0]                       nyq_now, hi_clamp, lo_sel, hi_sel;
	logic signed [wfps_pkg::BUF_W-1:0] mul_x;
	logic signed [16:0]               mul_y;
	logic [wfps_pkg::BUF_W-1:0]       mag_re, mag_im;
	logic [38:0]                      div_r2;
	logic                             div_ge;
	logic                             dbl;

	assign accept_in = in_valid & ~in_stall;
	assign out_free  = ~out_valid_q | ~out_stall;
	assign in_stall  = (state_q != wfps_pkg::ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	assign cnt_room  = cnt_q < 7'(wfps_pkg::NFFT_MAX);
	assign n_now     = cnt_q + (cnt_room ? 7'd1 : 7'd0);
	assign nfft      = 7'd1 << bits_q;
	assign samp_prod = in_data.sample * $signed({1'b0, in_data.weight});
	assign w_sq      = in_data.weight * in_data.weight;
	assign energy_sum = {1'b0, energy_q} + 38'(w_sq);

	always_comb begin
		bits_now = 3'd0;
		for (int b = 0; b < 7; b++) begin
			if ((7'd1 << b) < n_now) begin
				bits_now = 3'(b + 1);
			end
		end
	end

	// butterfly addressing for index idx_q within stage st_q
	always_comb begin
		half  = 7'd1 << st_q;
		kk    = idx_q & (half - 7'd1);
		base  = (idx_q >> st_q) << (st_q + 3'd1);
		bf_u  = base + kk;
		bf_v  = bf_u + half;
		tw_m  = 5'(kk << (3'd5 - st_q));
		tw    = wfps_pkg::twiddle(tw_m);
		for (int b = 0; b < 6; b++) begin
			rev6[b] = idx_q[5 - b];
		end
		rev   = 7'(rev6 >> (3'd6 - bits_q));
	end

	// bin range: clamp to Nyquist, empty or reversed range means all bins
	always_comb begin
		nyq_now  = 6'(nfft >> 1);
		hi_clamp = (last_q > nyq_now) ? nyq_now : last_q;
		if (first_q > hi_clamp) begin
			lo_sel = 6'd0;
			hi_sel = nyq_now;
		end else begin
			lo_sel = first_q;
			hi_sel = hi_clamp;
		end
	end

	always_comb begin
		unique case (state_q)
			wfps_pkg::ST_MUL0: begin mul_x = vr_q; mul_y = c_q; end
			wfps_pkg::ST_MUL1: begin mul_x = vi_q; mul_y = s_q; end
			wfps_pkg::ST_MUL2: begin mul_x = vi_q; mul_y = c_q; end
			default:           begin mul_x = vr_q; mul_y = s_q; end
		endcase
	end

	assign mag_re = ram_rre[wfps_pkg::BUF_W-1] ? -ram_rre : ram_rre;
	assign mag_im = ram_rim[wfps_pkg::BUF_W-1] ? -ram_rim : ram_rim;
	assign div_r2 = {rem_q, num_q[wfps_pkg::ACC_W-1]};
	assign div_ge = div_r2 >= {1'b0, wss_q};
	assign dbl    = (k_q != 6'd0) && (k_q != nyq_q);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			wfps_pkg::ST_IDLE: begin
				if (accept_in && in_data.last) begin
					state_d = (n_now >= 7'd4) ? wfps_pkg::ST_PAD : wfps_pkg::ST_LOAD;
				end
			end
			wfps_pkg::ST_PAD: begin
				if (idx_q == nfft) begin
					state_d = wfps_pkg::ST_SW_CHK;
				end
			end
			wfps_pkg::ST_SW_CHK: begin
				if (idx_q == nfft) begin
					state_d = wfps_pkg::ST_BF_CHK;
				end else if (idx_q < rev) begin
					state_d = wfps_pkg::ST_RD_A;
				end
			end
			wfps_pkg::ST_BF_CHK: begin
				state_d = (st_q == bits_q) ? wfps_pkg::ST_PW_RD : wfps_pkg::ST_RD_A;
			end
			wfps_pkg::ST_RD_A: state_d = wfps_pkg::ST_RD_B;
			wfps_pkg::ST_RD_B: state_d = wfps_pkg::ST_CAP;
			wfps_pkg::ST_CAP:  state_d = fft_q ? wfps_pkg::ST_MUL0 : wfps_pkg::ST_WR_A;
			wfps_pkg::ST_MUL0: state_d = wfps_pkg::ST_MUL1;
			wfps_pkg::ST_MUL1: state_d = wfps_pkg::ST_MUL2;
			wfps_pkg::ST_MUL2: state_d = wfps_pkg::ST_MUL3;
			wfps_pkg::ST_MUL3: state_d = wfps_pkg::ST_MUL4;
			wfps_pkg::ST_MUL4: state_d = wfps_pkg::ST_WR_A;
			wfps_pkg::ST_WR_A: state_d = wfps_pkg::ST_WR_B;
			wfps_pkg::ST_WR_B: state_d = fft_q ? wfps_pkg::ST_BF_CHK : wfps_pkg::ST_SW_CHK;
			wfps_pkg::ST_PW_RD:  state_d = wfps_pkg::ST_PW_CAP;
			wfps_pkg::ST_PW_CAP: state_d = wfps_pkg::ST_SQ_RE;
			wfps_pkg::ST_SQ_RE: begin
				if (m_q == '0) state_d = wfps_pkg::ST_SQ_IM;
			end
			wfps_pkg::ST_SQ_IM: begin
				if (m_q == '0) state_d = wfps_pkg::ST_SCALE;
			end
			wfps_pkg::ST_SCALE: begin
				if (m_q == '0) state_d = wfps_pkg::ST_DIV;
			end
			wfps_pkg::ST_DIV: begin
				if (dcnt_q == 7'd0) state_d = wfps_pkg::ST_LOAD;
			end
			wfps_pkg::ST_LOAD: begin
				if (out_free) begin
					state_d = (k_q == hi_q) ? wfps_pkg::ST_IDLE : wfps_pkg::ST_PW_RD;
				end
			end
			default: state_d = wfps_pkg::ST_IDLE;
		endcase
	end

	// buffer port control
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = addr_a_q;
		ram_wre   = '0;
		ram_wim   = '0;
		ram_raddr = addr_a_q;
		unique case (state_q)
			wfps_pkg::ST_IDLE: begin
				ram_we    = accept_in & cnt_room;
				ram_waddr = cnt_q[wfps_pkg::ADDR_W-1:0];
				ram_wre   = 48'(samp_prod);
			end
			wfps_pkg::ST_PAD: begin
				ram_we    = idx_q != nfft;
				ram_waddr = idx_q[wfps_pkg::ADDR_W-1:0];
			end
			wfps_pkg::ST_RD_B: ram_raddr = addr_b_q;
			wfps_pkg::ST_WR_A: begin
				ram_we    = 1'b1;
				ram_waddr = addr_a_q;
				ram_wre   = fft_q ? ur_q - tr_q : ur_q;
				ram_wim   = fft_q ? ui_q - ti_q : ui_q;
			end
			wfps_pkg::ST_WR_B: begin
				ram_we    = 1'b1;
				ram_waddr = addr_b_q;
				ram_wre   = fft_q ? ur_q + tr_q : vr_q;
				ram_wim   = fft_q ? ui_q + ti_q : vi_q;
			end
			wfps_pkg::ST_PW_RD: ram_raddr = k_q;
			default: ;
		endcase
	end

	// control state and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= wfps_pkg::ST_IDLE;
			step_q      <= wfps_pkg::STEP_RESET;
			first_q     <= wfps_pkg::FIRST_RESET;
			last_q      <= wfps_pkg::LAST_RESET;
			cnt_q       <= '0;
			energy_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				unique case (cfg_addr)
					wfps_pkg::REG_STEP_DAYS: step_q  <= cfg_wdata;
					wfps_pkg::REG_FIRST_BIN: first_q <= cfg_wdata[5:0];
					wfps_pkg::REG_LAST_BIN:  last_q  <= cfg_wdata[5:0];
					default: ;
				endcase
			end
			if (state_q == wfps_pkg::ST_IDLE && accept_in) begin
				if (in_data.last) begin
					cnt_q    <= '0;
					energy_q <= '0;
				end else if (cnt_room) begin
					cnt_q    <= n_now;
					energy_q <= energy_sum[37] ? '1 : energy_sum[36:0];
				end
			end
			if (state_q == wfps_pkg::ST_LOAD && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			wfps_pkg::ST_IDLE: begin
				if (accept_in && in_data.last) begin
					bits_q  <= bits_now;
					idx_q   <= n_now;
					fft_q   <= 1'b0;
					short_q <= n_now < 7'd4;
					// a short segment goes straight to the load with bin 0 alone
					k_q     <= '0;
					hi_q    <= '0;
					if (cnt_room) begin
						wss_q <= (energy_sum[37] ? 38'h1f_ffff_ffff : energy_sum) == '0 ?
							38'd1 << 30 : (energy_sum[37] ? 38'h1f_ffff_ffff : energy_sum);
					end else begin
						wss_q <= (energy_q == '0) ? 38'd1 << 30 : {1'b0, energy_q};
					end
				end
			end
			wfps_pkg::ST_PAD: begin
				idx_q <= (idx_q == nfft) ? 7'd0 : idx_q + 7'd1;
			end
			wfps_pkg::ST_SW_CHK: begin
				if (idx_q == nfft) begin
					idx_q <= '0;
					st_q  <= '0;
					fft_q <= 1'b1;
				end else if (idx_q < rev) begin
					addr_a_q <= idx_q[wfps_pkg::ADDR_W-1:0];
					addr_b_q <= rev[wfps_pkg::ADDR_W-1:0];
				end else begin
					idx_q <= idx_q + 7'd1;
				end
			end
			wfps_pkg::ST_BF_CHK: begin
				if (st_q == bits_q) begin
					k_q   <= lo_sel;
					hi_q  <= hi_sel;
					nyq_q <= nyq_now;
				end else begin
					addr_a_q <= bf_v[wfps_pkg::ADDR_W-1:0];
					addr_b_q <= bf_u[wfps_pkg::ADDR_W-1:0];
					c_q      <= tw.c;
					s_q      <= tw.s;
				end
			end
			wfps_pkg::ST_RD_B: begin
				vr_q <= ram_rre;
				vi_q <= ram_rim;
			end
			wfps_pkg::ST_CAP: begin
				ur_q <= ram_rre;
				ui_q <= ram_rim;
			end
			wfps_pkg::ST_MUL0: prod_q <= mul_x * mul_y;
			wfps_pkg::ST_MUL1: begin
				acc_q  <= 66'(prod_q);
				prod_q <= mul_x * mul_y;
			end
			wfps_pkg::ST_MUL2: begin
				tr_q   <= wfps_pkg::round_q15(acc_q + 66'(prod_q));
				prod_q <= mul_x * mul_y;
			end
			wfps_pkg::ST_MUL3: begin
				acc_q  <= 66'(prod_q);
				prod_q <= mul_x * mul_y;
			end
			wfps_pkg::ST_MUL4: ti_q <= wfps_pkg::round_q15(acc_q - 66'(prod_q));
			wfps_pkg::ST_WR_B: begin
				if (!fft_q) begin
					idx_q <= idx_q + 7'd1;
				end else if (idx_q + 7'd1 == (nfft >> 1)) begin
					idx_q <= '0;
					st_q  <= st_q + 3'd1;
				end else begin
					idx_q <= idx_q + 7'd1;
				end
			end
			wfps_pkg::ST_PW_CAP: begin
				m_q    <= mag_re[wfps_pkg::MAG_W-1:0];
				md_q   <= wfps_pkg::ACC_W'(mag_re[wfps_pkg::MAG_W-1:0]);
				mi_q   <= mag_im[wfps_pkg::MAG_W-1:0];
				pacc_q <= '0;
			end
			wfps_pkg::ST_SQ_RE, wfps_pkg::ST_SQ_IM, wfps_pkg::ST_SCALE: begin
				if (m_q == '0) begin
					if (state_q == wfps_pkg::ST_SQ_RE) begin
						m_q  <= mi_q;
						md_q <= wfps_pkg::ACC_W'(mi_q);
					end else if (state_q == wfps_pkg::ST_SQ_IM) begin
						m_q    <= wfps_pkg::MAG_W'(step_q);
						md_q   <= pacc_q;
						pacc_q <= '0;
					end else begin
						num_q  <= dbl ? pacc_q << 1 : pacc_q;
						rem_q  <= '0;
						dcnt_q <= 7'(wfps_pkg::ACC_W - 1);
						q_q    <= '0;
						over_q <= 1'b0;
					end
				end else begin
					if (m_q[0]) begin
						pacc_q <= pacc_q + md_q;
					end
					m_q  <= m_q >> 1;
					md_q <= md_q << 1;
				end
			end
			wfps_pkg::ST_DIV: begin
				rem_q  <= div_ge ? 38'(div_r2 - {1'b0, wss_q}) : div_r2[37:0];
				num_q  <= num_q << 1;
				q_q    <= {q_q[46:0], div_ge && dcnt_q < 7'(wfps_pkg::POWER_W)};
				if (div_ge && dcnt_q >= 7'(wfps_pkg::POWER_W)) begin
					over_q <= 1'b1;
				end
				dcnt_q <= dcnt_q - 7'd1;
			end
			wfps_pkg::ST_LOAD: begin
				if (out_free) begin
					out_q.bin_index     <= k_q;
					out_q.power         <= short_q ? '0 : (over_q ? '1 : q_q);
					out_q.short_segment <= short_q;
					out_q.last_bin_flag <= k_q == hi_q;
					k_q                 <= k_q + 6'd1;
				end
			end
			default: ;
		endcase
	end

	wfps_ram #(
		.WIDTH(wfps_pkg::BUF_W),
		.DEPTH(wfps_pkg::NFFT_MAX)
	) u_buf_re (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wre),
		.raddr (ram_raddr),
		.rdata (ram_rre)
	);

	wfps_ram #(
		.WIDTH(wfps_pkg::BUF_W),
		.DEPTH(wfps_pkg::NFFT_MAX)
	) u_buf_im (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wim),
		.raddr (ram_raddr),
		.rdata (ram_rim)
	);

endmodule

### bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: windowed FFT power spectrum bench
// Drives windowed segments through the block under random idling on both
// sides, predicts every PSD beat with a bit-exact software FFT and checks
// the output stream in order. Register settings change between phases.
// ----------------------------------------------------------------------------
module tb;

	typedef struct packed {
		logic signed [15:0] smp;
		logic [15:0]        wgt;
		logic               lst;
		logic               chk;   // typed-in expectation follows
		logic [47:0]        pwr;
	} stim_row_t;

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_stall;
	wfps_pkg::in_item_t  in_data;
	logic                out_valid;
	logic                out_stall;
	wfps_pkg::out_item_t out_data;
	logic                cfg_we;
	logic [1:0]          cfg_addr;
	logic [31:0]         cfg_wdata;

	// predictor state
	logic [31:0]         step_q;
	logic [5:0]          first_q;
	logic [5:0]          last_q;
	logic signed [63:0]  seg_re [64];
	logic signed [63:0]  seg_im [64];
	int unsigned         seg_len;
	logic [36:0]         seg_energy;

	wfps_pkg::out_item_t psd_expected [$];
	int                  err_count;
	int                  idle_cycles;
	bit                  calm;         // no idling on either side
	bit                  pinned_power; // directed row with a typed-in value
	logic [47:0]         pinned_value;

	windowed_fft_power_spectrum uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic report(input string what);
		$display("MISMATCH @%0t: %s", $realtime, what);
		err_count++;
	endtask

	function automatic logic signed [63:0] rnd15(input logic signed [63:0] x);
		logic [63:0] m;
		m = x < 0 ? -x : x;
		m = (m + 64'd16384) >> 15;
		return x < 0 ? -$signed(m) : $signed(m);
	endfunction

	function automatic logic signed [17:0] cos_q15(input int m);
		int q [17] = '{32768, 32610, 32138, 31357, 30274, 28899, 27246, 25330,
			23170, 20788, 18205, 15447, 12540, 9512, 6393, 3212, 0};
		return 18'(q[m]);
	endfunction

	// in-place radix-2 transform of the first nfft points
	task automatic transform_segment(input int nfft, input int bits);
		int                 j, stride, m, u, v;
		logic signed [63:0] c, s, tr, ti, t;
		for (int i = 0; i < nfft; i++) begin
			j = 0;
			for (int b = 0; b < bits; b++)
				j |= ((i >> b) & 1) << (bits - 1 - b);
			if (i < j) begin
				t = seg_re[i]; seg_re[i] = seg_re[j]; seg_re[j] = t;
				t = seg_im[i]; seg_im[i] = seg_im[j]; seg_im[j] = t;
			end
		end
		for (int len = 2; len <= nfft; len <<= 1) begin
			stride = 64 / len;
			for (int base = 0; base < nfft; base += len)
				for (int k = 0; k < len / 2; k++) begin
					m = (k * stride) & 31;
					c = m <= 16 ? cos_q15(m) : -cos_q15(32 - m);
					s = m <= 16 ? cos_q15(16 - m) : cos_q15(m - 16);
					u = base + k;
					v = base + k + len / 2;
					tr = rnd15(seg_re[v] * c + seg_im[v] * s);
					ti = rnd15(seg_im[v] * c - seg_re[v] * s);
					seg_re[v] = seg_re[u] - tr;
					seg_im[v] = seg_im[u] - ti;
					seg_re[u] = seg_re[u] + tr;
					seg_im[u] = seg_im[u] + ti;
				end
		end
	endtask

	// one accepted sample beat: queue the PSD beats it closes, if any
	task automatic predict_psd(input wfps_pkg::in_item_t it);
		int                  n, nfft, bits, nyq, lo, hi;
		logic [37:0]         divisor;
		logic [127:0]        num, q;
		logic [63:0]         mr, mi;
		wfps_pkg::out_item_t r;
		if (seg_len < 64) begin
			seg_re[seg_len] = 64'(it.sample) * $signed({48'd0, it.weight});
			seg_im[seg_len] = 0;
			if (38'(seg_energy) + 38'(32'(it.weight) * 32'(it.weight)) > 38'h1F_FFFF_FFFF)
				seg_energy = '1;
			else
				seg_energy = seg_energy + 37'(32'(it.weight) * 32'(it.weight));
			seg_len++;
		end
		if (!it.last)
			return;
		n = seg_len;
		divisor = seg_energy == 0 ? 38'd1 << 30 : 38'(seg_energy);
		seg_len = 0;
		seg_energy = 0;
		if (n < 4) begin
			r = '{bin_index: 6'd0, power: 48'd0, short_segment: 1'b1, last_bin_flag: 1'b1};
			psd_expected = {psd_expected, r};
			return;
		end
		nfft = 1;
		bits = 0;
		while (nfft < n) begin
			nfft <<= 1;
			bits++;
		end
		for (int k = n; k < nfft; k++) begin
			seg_re[k] = 0;
			seg_im[k] = 0;
		end
		transform_segment(nfft, bits);
		nyq = nfft / 2;
		lo = first_q;
		hi = last_q > nyq ? nyq : last_q;
		if (lo > hi) begin
			lo = 0;
			hi = nyq;
		end
		for (int k = lo; k <= hi; k++) begin
			mr = seg_re[k] < 0 ? -seg_re[k] : seg_re[k];
			mi = seg_im[k] < 0 ? -seg_im[k] : seg_im[k];
			num = (128'(mr) * mr + 128'(mi) * mi) * step_q;
			if (k != 0 && k != nyq)
				num = num << 1;
			q = num / divisor;
			r.bin_index = 6'(k);
			r.power = q > 128'hFFFF_FFFF_FFFF ? '1 : q[47:0];
			r.short_segment = 1'b0;
			r.last_bin_flag = k == hi;
			psd_expected = {psd_expected, r};
		end
	endtask

	// send one beat; valid stays high into the next beat unless that beat idles first
	task automatic send_beat(input wfps_pkg::in_item_t it);
		if (!calm && $urandom_range(99) < 35) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= it;
		do
			@(posedge clk);
		while (in_stall);
		predict_psd(it);
	endtask

	task automatic drain_outputs();
		in_valid <= 1'b0;
		while (psd_expected.size() != 0)
			@(posedge clk);
		repeat (50) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
		cfg_we    <= 1'b1;
		cfg_addr  <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			wfps_pkg::REG_STEP_DAYS: step_q  = val;
			wfps_pkg::REG_FIRST_BIN: first_q = val[5:0];
			wfps_pkg::REG_LAST_BIN:  last_q  = val[5:0];
			default: ;
		endcase
	endtask

	function automatic wfps_pkg::in_item_t rand_sample(input bit lst);
		wfps_pkg::in_item_t it;
		it.sample = 16'($urandom);
		case ($urandom_range(3))
			0: it.weight = 16'($urandom);
			1: it.weight = 16'd32768;
			default: it.weight = 16'($urandom_range(0, 32768));
		endcase
		it.last = lst;
		return it;
	endfunction

	// output side: random stall, compare each beat with the oldest expectation
	initial begin
		wfps_pkg::out_item_t e;
		out_stall = 1'b1;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall) begin
				if (psd_expected.size() == 0)
					report($sformatf("unexpected beat bin %0d", out_data.bin_index));
				else begin
					e = psd_expected.pop_front();
					if (pinned_power && out_data.power !== pinned_value)
						report($sformatf("pinned power %0h", out_data.power));
					if (out_data.bin_index !== e.bin_index)
						report($sformatf("bin %0d exp %0d", out_data.bin_index, e.bin_index));
					if (out_data.power !== e.power)
						report($sformatf("bin %0d power %0h exp %0h",
							e.bin_index, out_data.power, e.power));
					if (out_data.short_segment !== e.short_segment)
						report($sformatf("bin %0d short flag", e.bin_index));
					if (out_data.last_bin_flag !== e.last_bin_flag)
						report($sformatf("bin %0d closing flag", e.bin_index));
				end
			end
			out_stall <= !calm && $urandom_range(99) < 35;
		end
	end

	// watchdog: cycles with no beat accepted on either side
	initial begin
		idle_cycles = 0;
		forever begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles = 0;
			else if (++idle_cycles >= 400000) begin
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	initial begin
		stim_row_t rows [12] = '{
			// too short: error beat, power zero
			'{16'sh7FFF, 16'd32768, 1'b0, 1'b0, 48'd0},
			'{16'sh8000, 16'd32768, 1'b1, 1'b1, 48'd0},
			// single sample closes at once
			'{16'sd5, 16'd0, 1'b1, 1'b1, 48'd0},
			// four zero-weight samples: energy taken as one, all powers zero
			'{16'sh7FFF, 16'd0, 1'b0, 1'b0, 48'd0},
			'{16'sh8000, 16'd0, 1'b0, 1'b0, 48'd0},
			'{16'sh7FFF, 16'd0, 1'b0, 1'b0, 48'd0},
			'{16'sh8000, 16'd0, 1'b1, 1'b1, 48'd0},
			// five extremes, padded to eight
			'{16'sh7FFF, 16'd32768, 1'b0, 1'b0, 48'd0},
			'{16'sh8000, 16'd32768, 1'b0, 1'b0, 48'd0},
			'{16'sh7FFF, 16'd65535, 1'b0, 1'b0, 48'd0},
			'{16'sh8000, 16'd65535, 1'b0, 1'b0, 48'd0},
			'{16'sh0000, 16'd1, 1'b1, 1'b0, 48'd0}
		};
		wfps_pkg::in_item_t it;
		int                 seg;
		calm = 1'b0;
		pinned_power = 1'b0;
		err_count = 0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_we = 1'b0;
		cfg_addr = wfps_pkg::REG_STEP_DAYS;
		cfg_wdata = '0;
		step_q = wfps_pkg::STEP_RESET;
		first_q = wfps_pkg::FIRST_RESET;
		last_q = wfps_pkg::LAST_RESET;
		seg_len = 0;
		seg_energy = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i]) begin
			it = '{sample: rows[i].smp, weight: rows[i].wgt, last: rows[i].lst};
			send_beat(it);
			if (rows[i].lst) begin
				pinned_power = rows[i].chk;
				pinned_value = rows[i].pwr;
				drain_outputs();
				pinned_power = 1'b0;
			end
		end

		// overlong segment: samples past 64 dropped, last still closes
		for (int i = 0; i < 70; i++)
			send_beat(rand_sample(i == 69));
		drain_outputs();

		// register phases, extremes among them
		for (int ph = 0; ph < 7; ph++) begin
			case (ph)
				0: begin
					write_reg(wfps_pkg::REG_STEP_DAYS, 32'hFFFF_FFFF);
					write_reg(wfps_pkg::REG_FIRST_BIN, 32'd63);
					write_reg(wfps_pkg::REG_LAST_BIN, 32'd0);
				end
				1: begin
					write_reg(wfps_pkg::REG_STEP_DAYS, 32'd0);
					write_reg(wfps_pkg::REG_FIRST_BIN, 32'd0);
					write_reg(wfps_pkg::REG_LAST_BIN, 32'd63);
				end
				2: begin
					write_reg(wfps_pkg::REG_STEP_DAYS, 32'd1);
					write_reg(wfps_pkg::REG_FIRST_BIN, 32'd2);
					write_reg(wfps_pkg::REG_LAST_BIN, 32'd5);
				end
				3: calm = 1'b1;
				4: begin
					calm = 1'b0;
					write_reg(wfps_pkg::REG_STEP_DAYS, wfps_pkg::STEP_RESET);
					write_reg(wfps_pkg::REG_FIRST_BIN, 32'd32);
					write_reg(wfps_pkg::REG_LAST_BIN, 32'd32);
				end
				default: begin
					write_reg(wfps_pkg::REG_STEP_DAYS, $urandom);
					write_reg(wfps_pkg::REG_FIRST_BIN, 32'($urandom_range(0, 40)));
					write_reg(wfps_pkg::REG_LAST_BIN, $urandom);
				end
			endcase
			// mostly short well-formed segments, now and then a long one
			for (seg = 0; seg < 2; seg++) begin
				int len;
				len = $urandom_range(99) < 10 ? $urandom_range(33, 64) :
					$urandom_range(1, 12);
				for (int i = 0; i < len; i++)
					send_beat(rand_sample(i == len - 1));
			end
			drain_outputs();
		end

		if (err_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

### sim.f
rtl/core/wfps_pkg.sv
rtl/core/wfps_ram.sv
rtl/core/windowed_fft_power_spectrum.sv
bench/tb.sv
